### rtl/core/pba_pkg.sv
`default_nettype none
package pba_pkg;
   localparam int MapWords = 1024;
   localparam int WordAw = 10;
   localparam int PageAw = 15;
   localparam int MaxRun = 1024;
   localparam logic [31:0] FullWord = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE = 2'd1,
      MODE_TEST = 2'd2,
      MODE_NOP = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_BELOW_BASE = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      REG_BASE = 1'd0,
      REG_WORDS = 1'd1
   } reg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [10:0] page_count;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [31:0] result_address;
      logic [1:0] status;
      logic page_used;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_DECODE, S_SRD, S_SCAN, S_MRD, S_MARK, S_HRD, S_HINT,
      S_FRD, S_FREE, S_TRD, S_TEST, S_DONE
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic srd;
      logic scan;
      logic mrd;
      logic mark;
      logic hrd;
      logic hint;
      logic frd;
      logic free;
      logic trd;
      logic test;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic is_alloc;
      logic is_free;
      logic is_test;
      logic scan_end;
      logic found;
      logic mark_end;
      logic hint_end;
      logic free_end;
   } sts_type;
endpackage
`default_nettype wire

### rtl/core/pba_ctrl.sv
`default_nettype none
module pba_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input wire logic rsp_ready,
   input wire pba_pkg::sts_type sts,
   output pba_pkg::cmd_type cmd
);
   pba_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pba_pkg::S_CLEAR;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         pba_pkg::S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = pba_pkg::S_IDLE;
         end
         pba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = pba_pkg::S_DECODE;
            end
         end
         pba_pkg::S_DECODE: begin
            if (sts.is_alloc) state_in = pba_pkg::S_SRD;
            else if (sts.is_free) state_in = pba_pkg::S_FRD;
            else if (sts.is_test) state_in = pba_pkg::S_TRD;
            else state_in = pba_pkg::S_DONE;
         end
         pba_pkg::S_SRD: begin
            cmd.srd = 1'b1;
            state_in = pba_pkg::S_SCAN;
         end
         pba_pkg::S_SCAN: begin
            if (sts.scan_end) begin
               cmd.finish = !sts.found;
               state_in = sts.found ? pba_pkg::S_MRD : pba_pkg::S_DONE;
            end else begin
               cmd.scan = 1'b1;
               state_in = pba_pkg::S_SRD;
            end
         end
         pba_pkg::S_MRD: begin
            cmd.mrd = 1'b1;
            state_in = pba_pkg::S_MARK;
         end
         pba_pkg::S_MARK: begin
            cmd.mark = 1'b1;
            state_in = sts.mark_end ? pba_pkg::S_HRD : pba_pkg::S_MRD;
         end
         pba_pkg::S_HRD: begin
            if (sts.hint_end) state_in = pba_pkg::S_DONE;
            else begin
               cmd.hrd = 1'b1;
               state_in = pba_pkg::S_HINT;
            end
         end
         pba_pkg::S_HINT: begin
            cmd.hint = 1'b1;
            state_in = pba_pkg::S_HRD;
         end
         pba_pkg::S_FRD: begin
            if (sts.free_end) state_in = pba_pkg::S_DONE;
            else begin
               cmd.frd = 1'b1;
               state_in = pba_pkg::S_FREE;
            end
         end
         pba_pkg::S_FREE: begin
            cmd.free = 1'b1;
            state_in = pba_pkg::S_FRD;
         end
         pba_pkg::S_TRD: begin
            cmd.trd = 1'b1;
            state_in = pba_pkg::S_TEST;
         end
         pba_pkg::S_TEST: begin
            cmd.test = 1'b1;
            state_in = pba_pkg::S_DONE;
         end
         pba_pkg::S_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = pba_pkg::S_IDLE;
         end
         default: state_in = pba_pkg::S_CLEAR;
      endcase
   end
endmodule
`default_nettype wire

### rtl/core/pba_dp.sv
`default_nettype none
module pba_dp (
   input wire logic clock,
   input wire logic reset,
   input wire pba_pkg::cmd_type cmd,
   output pba_pkg::sts_type sts,
   input wire pba_pkg::req_type req_data,
   output pba_pkg::rsp_type rsp_data,
   input wire logic [31:0] base_address,
   input wire logic [10:0] words_in_use
);
   logic [31:0] mem [pba_pkg::MapWords];
   logic [31:0] rd_ff;
   logic [pba_pkg::WordAw:0] clr_ff, clr_in;
   logic [pba_pkg::WordAw:0] hint_ff, hint_in;
   pba_pkg::req_type req_ff;
   logic [1:0] status_ff, status_in;
   logic used_ff, used_in;
   logic [31:0] res_ff, res_in;
   logic [pba_pkg::WordAw:0] wcur_ff, wcur_in;
   logic [10:0] run_ff, run_in;
   logic [pba_pkg::PageAw:0] start_ff, start_in;
   logic [10:0] left_ff, left_in;
   logic [pba_pkg::PageAw:0] pcur_ff, pcur_in;
   logic found_ff, found_in;
   logic any_ff, any_in;
   logic [pba_pkg::WordAw:0] live;
   logic [pba_pkg::PageAw:0] limit;
   logic [31:0] off;
   logic [31:0] ld_off;
   logic below;
   logic [19:0] fpage;
   logic cnt_ok;
   logic we;
   logic [pba_pkg::WordAw-1:0] waddr, raddr;
   logic [31:0] wdata;
   logic re;
   logic [5:0] last_used [32];
   logic [10:0] run_at [32];
   logic [5:0] hit;
   logic [31:0] mask;
   logic [5:0] lo, n;
   logic [10:0] take;
   logic [pba_pkg::PageAw:0] pend;
   logic hint_stop;
   logic hstop_ff;

   assign live = (words_in_use > 11'(pba_pkg::MapWords)) ?
      11'(pba_pkg::MapWords) : words_in_use;
   assign limit = {live, 5'd0};
   assign off = req_ff.address - base_address;
   assign ld_off = req_data.address - base_address;
   assign below = req_ff.address < base_address;
   assign fpage = off[31:12];
   assign cnt_ok = req_ff.page_count != 11'd0 &&
      req_ff.page_count <= 11'(pba_pkg::MaxRun);

   // free run length ending at each bit, from the last used bit at or below it
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         last_used[i] = 6'd0;
         for (int j = 0; j <= i; j++)
            if (rd_ff[j]) last_used[i] = 6'(j + 1);
         run_at[i] = (last_used[i] == 6'd0) ? run_ff + 11'(i + 1) :
            11'(i + 1) - 11'(last_used[i]);
      end
      hit = 6'd0;
      for (int i = 31; i >= 0; i--)
         if (run_at[i] == req_ff.page_count) hit = 6'(i + 1);
   end

   assign lo = {1'b0, pcur_ff[4:0]};
   assign take = (11'd32 - 11'(lo) < left_ff) ? 11'd32 - 11'(lo) : left_ff;
   assign n = take[5:0];
   always_comb begin
      mask = '0;
      for (int i = 0; i < 32; i++)
         mask[i] = (6'(i) >= lo) && (6'(i) < lo + n);
   end
   assign pend = pcur_ff + 16'(take);

   always_comb begin
      re = 1'b0;
      raddr = wcur_ff[pba_pkg::WordAw-1:0];
      if (cmd.srd) re = 1'b1;
      if (cmd.mrd || cmd.frd) begin
         re = 1'b1;
         raddr = pcur_ff[pba_pkg::PageAw-1:5];
      end
      if (cmd.hrd) begin
         re = 1'b1;
         raddr = hint_ff[pba_pkg::WordAw-1:0];
      end
      if (cmd.trd) begin
         re = 1'b1;
         raddr = fpage[pba_pkg::PageAw-1:5];
      end
   end

   always_comb begin
      we = 1'b0;
      waddr = pcur_ff[pba_pkg::PageAw-1:5];
      wdata = rd_ff | mask;
      if (cmd.clr_step) begin
         we = 1'b1;
         waddr = clr_ff[pba_pkg::WordAw-1:0];
         wdata = '0;
      end
      if (cmd.mark) we = 1'b1;
      if (cmd.free) begin
         we = 1'b1;
         wdata = rd_ff & ~mask;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_ff <= mem[raddr];
   end

   always_comb begin
      clr_in = clr_ff + 11'(cmd.clr_step);
      hint_in = hint_ff;
      status_in = status_ff;
      used_in = used_ff;
      res_in = res_ff;
      wcur_in = wcur_ff;
      run_in = run_ff;
      start_in = start_ff;
      left_in = left_ff;
      pcur_in = pcur_ff;
      found_in = found_ff;
      any_in = any_ff;
      if (cmd.load) begin
         status_in = pba_pkg::ST_OK;
         used_in = 1'b0;
         res_in = '0;
         wcur_in = hint_ff;
         run_in = '0;
         found_in = 1'b0;
         any_in = 1'b0;
         pcur_in = ld_off[27:12];
         left_in = req_data.page_count;
      end
      if (cmd.scan) begin
         if (hit != 6'd0) begin
            found_in = 1'b1;
            start_in = 16'({wcur_ff, 5'd0} + 16'(hit)) - 16'(req_ff.page_count);
            pcur_in = 16'({wcur_ff, 5'd0} + 16'(hit)) - 16'(req_ff.page_count);
            left_in = req_ff.page_count;
         end
         run_in = run_at[31];
         wcur_in = wcur_ff + 11'd1;
      end
      if (cmd.finish) status_in = pba_pkg::ST_NOT_FOUND;
      if (cmd.mark || cmd.free) begin
         pcur_in = pend;
         left_in = left_ff - take;
      end
      if (cmd.mark && left_ff == take)
         res_in = base_address + {4'd0, start_ff, 12'd0};
      if (cmd.free) begin
         any_in = 1'b1;
         if (!any_ff && {5'd0, fpage[15:5]} < {5'd0, hint_ff}) hint_in = fpage[15:5];
      end
      if (cmd.hint && rd_ff == pba_pkg::FullWord) hint_in = hint_ff + 11'd1;
      if (cmd.test) used_in = ({4'd0, fpage} < {8'd0, limit}) && rd_ff[fpage[4:0]];
      if (cmd.test && below) begin
         status_in = pba_pkg::ST_BELOW_BASE;
         used_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         hint_ff <= '0;
         status_ff <= '0;
         used_ff <= 1'b0;
         res_ff <= '0;
         found_ff <= 1'b0;
         any_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         hint_ff <= hint_in;
         status_ff <= status_in;
         used_ff <= used_in;
         res_ff <= res_in;
         found_ff <= found_in;
         any_ff <= any_in;
      end
      wcur_ff <= wcur_in;
      run_ff <= run_in;
      start_ff <= start_in;
      left_ff <= left_in;
      pcur_ff <= pcur_in;
      if (cmd.load) req_ff <= req_data;
   end

   assign hint_stop = hint_ff >= live || (cmd.hint && rd_ff != pba_pkg::FullWord);
   always_ff @(posedge clock) begin
      if (reset || cmd.load) hstop_ff <= 1'b0;
      else if (cmd.hint && rd_ff != pba_pkg::FullWord) hstop_ff <= 1'b1;
   end

   always_comb begin
      sts.clr_done = clr_ff == 11'(pba_pkg::MapWords - 1);
      sts.is_alloc = req_ff.mode == pba_pkg::MODE_ALLOC;
      sts.is_free = req_ff.mode == pba_pkg::MODE_FREE;
      sts.is_test = req_ff.mode == pba_pkg::MODE_TEST;
      sts.found = found_ff;
      sts.scan_end = !cnt_ok || found_ff || wcur_ff >= live;
      sts.mark_end = left_ff == take;
      sts.hint_end = hint_stop || hstop_ff;
      sts.free_end = below || !cnt_ok || left_ff == 11'd0 || pcur_ff >= limit ||
         fpage[19:16] != 4'd0;
   end

   assign rsp_data.result_address = res_ff;
   assign rsp_data.status = status_ff;
   assign rsp_data.page_used = used_ff;
endmodule
`default_nettype wire

### rtl/core/page_bitmap_allocator.sv
// Page bitmap allocator, first fit over a 1024-word page map.
// Requests enter on req_valid/req_ready, one transaction at a time; the
// single response leaves on rsp_valid/rsp_ready and is held while the
// receiver stalls. No new request is taken until the response is taken.
// Allocate scans map words one at a time from the hint word (read, then
// evaluate in the memory's registered read port), then marks one word
// at a time and moves the hint over full words. Free reads and clears
// each word of the run in turn. Test reads the page's word and responds.
// After reset the block clears the map, one word a cycle, with req_ready
// low; CSR writes are taken during that pass.
// CSR: 0 base_address, 1 words_in_use at byte offsets 0 and 4.
`default_nettype none
module page_bitmap_allocator (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire pba_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output pba_pkg::rsp_type rsp_data,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [2:2] paddr,
   input wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   logic [31:0] base_ff;
   logic [10:0] words_ff;
   pba_pkg::cmd_type cmd;
   pba_pkg::sts_type sts;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         words_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (paddr)
            pba_pkg::REG_BASE: base_ff <= pwdata;
            pba_pkg::REG_WORDS: words_ff <= pwdata[10:0];
            default: ;
         endcase
      end
   end
   assign prdata = (paddr == pba_pkg::REG_BASE) ? base_ff : {21'd0, words_ff};

   pba_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );

   pba_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req_data(req_data),
      .rsp_data(rsp_data), .base_address(base_ff), .words_in_use(words_ff)
   );
endmodule
`default_nettype wire

### bench/pba_checker.sv
`timescale 1ns / 100ps
module pba_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire pba_pkg::req_type req_data,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire pba_pkg::rsp_type rsp_data,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [2:2] paddr,
   input wire logic [31:0] pwdata,
   input wire logic pready,
   output int pending,
   output int errors
);
   logic [31:0] page_map [pba_pkg::MapWords];
   int unsigned hint_word;
   logic [31:0] base_addr;
   logic [10:0] words_used;
   pba_pkg::rsp_type expected_rsps[$];

   initial begin
      errors = 0;
      pending = 0;
   end

   function automatic int unsigned live_words();
      return (words_used > pba_pkg::MapWords) ? pba_pkg::MapWords : words_used;
   endfunction

   task automatic report(input string what, input logic [31:0] exp, input logic [31:0] got);
      $display("%0t mismatch %s: expected %0h got %0h", $time, what, exp, got);
      errors++;
   endtask

   task automatic apply_request(input pba_pkg::req_type r, output pba_pkg::rsp_type o);
      int unsigned lim, p, run, start, cnt, i;
      logic found, any;
      o = '0;
      lim = live_words() * 32;
      cnt = r.page_count;
      found = 0;
      any = 0;
      run = 0;
      start = 0;
      case (pba_pkg::mode_type'(r.mode))
         pba_pkg::MODE_ALLOC: begin
            if (cnt >= 1 && cnt <= pba_pkg::MaxRun) begin
               for (p = hint_word * 32; p < lim; p++) begin
                  if (page_map[p[14:5]][p[4:0]]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == cnt) begin
                        start = p + 1 - cnt;
                        found = 1;
                        break;
                     end
                  end
               end
            end
            if (found) begin
               for (i = 0; i < cnt; i++) begin
                  p = start + i;
                  page_map[p[14:5]][p[4:0]] = 1'b1;
               end
               while (hint_word < live_words() && page_map[hint_word] == pba_pkg::FullWord)
                  hint_word++;
               o.result_address = base_addr + start * 32'h1000;
            end else begin
               o.status = pba_pkg::ST_NOT_FOUND;
            end
         end
         pba_pkg::MODE_FREE: begin
            if (r.address >= base_addr && cnt >= 1 && cnt <= pba_pkg::MaxRun) begin
               start = (r.address - base_addr) >> 12;
               for (i = 0; i < cnt; i++) begin
                  p = start + i;
                  if (p < start || p >= lim) break;
                  page_map[p[14:5]][p[4:0]] = 1'b0;
                  any = 1;
               end
               if (any && (start >> 5) < hint_word) hint_word = start >> 5;
            end
         end
         pba_pkg::MODE_TEST: begin
            if (r.address < base_addr) begin
               o.status = pba_pkg::ST_BELOW_BASE;
            end else begin
               p = (r.address - base_addr) >> 12;
               if (p < lim && page_map[p[14:5]][p[4:0]]) o.page_used = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      pba_pkg::rsp_type pred, exp;
      if (reset) begin
         foreach (page_map[i]) page_map[i] = '0;
         hint_word = 0;
         base_addr = '0;
         words_used = '0;
         expected_rsps.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (pba_pkg::reg_type'(paddr[2]))
               pba_pkg::REG_BASE: base_addr = pwdata;
               pba_pkg::REG_WORDS: words_used = pwdata[10:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            apply_request(req_data, pred);
            expected_rsps.push_back(pred);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report("unexpected transaction", '0, rsp_data.result_address);
            end else begin
               exp = expected_rsps.pop_front();
               if (rsp_data.result_address !== exp.result_address)
                  report("result_address", exp.result_address, rsp_data.result_address);
               if (rsp_data.status !== exp.status)
                  report("status", 32'(exp.status), 32'(rsp_data.status));
               if (rsp_data.page_used !== exp.page_used)
                  report("page_used", 32'(exp.page_used), 32'(rsp_data.page_used));
            end
         end
      end
      pending = expected_rsps.size();
   end
endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   pba_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   pba_pkg::rsp_type rsp_data;
   logic psel, penable, pwrite;
   logic [2:2] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;
   int pending, errors;
   int cycles;
   int sent;
   int settings;
   logic quiet;

   localparam int CycleLimit = 20_000_000;

   page_bitmap_allocator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pba_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .pending(pending), .errors(errors)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(input pba_pkg::reg_type idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= idx;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] base, input logic [10:0] words);
      wait_idle();
      csr_write(pba_pkg::REG_BASE, base);
      csr_write(pba_pkg::REG_WORDS, words);
      settings++;
   endtask

   task automatic send(input pba_pkg::mode_type m, input logic [10:0] cnt,
                       input logic [31:0] addr);
      if (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{mode: m, page_count: cnt, address: addr};
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic random_request(input logic [31:0] base, input logic [10:0] words);
      int unsigned lim, pick;
      logic [31:0] page_addr;
      logic [10:0] cnt;
      lim = ((words > pba_pkg::MapWords) ? pba_pkg::MapWords : words) * 32;
      page_addr = base + $urandom_range(lim + 8) * 32'h1000 + $urandom_range(4095);
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) cnt = 11'($urandom_range(9, 40));
      else if ($urandom_range(49) == 0) cnt = 11'($urandom_range(1, pba_pkg::MaxRun));
      else cnt = 11'($urandom_range(1, 8));
      if (pick < 40)
         send(pba_pkg::MODE_ALLOC, cnt, $urandom);
      else if (pick < 68)
         send(pba_pkg::MODE_FREE, cnt, page_addr);
      else if (pick < 93)
         send(pba_pkg::MODE_TEST, 11'($urandom), page_addr);
      else
         send(pba_pkg::mode_type'($urandom_range(3)), 11'($urandom), $urandom);
   endtask

   logic [31:0] phase_base [10];
   logic [10:0] phase_words [10];

   initial begin
      req_valid = 0;
      req_data = '0;
      rsp_ready = 1;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      reset = 1;
      cycles = 0;
      sent = 0;
      settings = 0;
      quiet = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      configure(32'h1000_0000, 11'd2);
      send(pba_pkg::MODE_ALLOC, 11'd1, '0);
      send(pba_pkg::MODE_ALLOC, 11'd0, '0);
      send(pba_pkg::MODE_ALLOC, 11'd1025, '0);
      send(pba_pkg::MODE_ALLOC, 11'd2047, '0);
      send(pba_pkg::MODE_ALLOC, 11'd64, '0);
      send(pba_pkg::MODE_ALLOC, 11'd40, '0);
      send(pba_pkg::MODE_TEST, '0, 32'h1000_0000);
      send(pba_pkg::MODE_TEST, '0, 32'h1002_8fff);
      send(pba_pkg::MODE_TEST, '0, 32'h0fff_ffff);
      send(pba_pkg::MODE_TEST, '0, 32'h1004_0000);
      send(pba_pkg::MODE_TEST, 11'h7ff, 32'hffff_ffff);
      send(pba_pkg::MODE_ALLOC, 11'd23, '0);
      send(pba_pkg::MODE_ALLOC, 11'd1, '0);
      send(pba_pkg::MODE_FREE, 11'd4, 32'h0fff_f000);
      send(pba_pkg::MODE_FREE, 11'd0, 32'h1000_0000);
      send(pba_pkg::MODE_FREE, 11'd1025, 32'h1000_0000);
      send(pba_pkg::MODE_FREE, 11'd8, 32'h1003_e000);
      send(pba_pkg::MODE_FREE, 11'd1024, 32'h1004_0000);
      send(pba_pkg::MODE_NOP, 11'h7ff, 32'hffff_ffff);
      send(pba_pkg::MODE_ALLOC, 11'd3, '0);
      send(pba_pkg::MODE_FREE, 11'd1024, 32'h1000_0000);
      send(pba_pkg::MODE_ALLOC, 11'd64, '0);

      phase_base = '{32'h0, 32'hffff_ffff, $urandom, 32'h0, $urandom,
                     32'hffff_f000, $urandom, $urandom, 32'h0, $urandom};
      phase_words = '{11'd0, 11'd1, 11'd3, 11'd8, 11'd16,
                      11'd32, 11'd1024, 11'd2047, 11'd5, 11'd12};
      for (int ph = 0; ph < 10; ph++) begin
         configure(phase_base[ph], phase_words[ph]);
         quiet = (ph == 4);
         for (int n = 0; n < ((phase_words[ph] >= pba_pkg::MapWords) ? 50 : 138); n++)
            random_request(phase_base[ph], phase_words[ph]);
         req_valid <= 1'b0;
      end
      quiet = 0;

      wait_idle();
      $display("Sent %0d requests over %0d register settings, %0d mismatches.",
               sent, settings, errors);
      $display("Covered alloc, free, test and no-op with bad lengths and out-of-range pages.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
